FILE: rtl/core/tmcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmcd_pkg;

    localparam int COL_W       = 6;
    localparam int LINE_W      = 8;
    localparam int ADDR_W      = 11;
    localparam int DATA_W      = 8;
    localparam int VADDR_W     = 10;
    localparam int CELL_LINES  = 16;
    localparam int VIDEO_DEPTH = 1024;
    localparam int GLYPH_DEPTH = 2048;

    localparam logic [1:0] OP_VIDEO_WR = 2'd0;
    localparam logic [1:0] OP_GLYPH_WR = 2'd1;
    localparam logic [1:0] OP_EMIT     = 2'd2;

    typedef enum logic [1:0] {
        KIND_VIDEO_WR,
        KIND_GLYPH_WR,
        KIND_EMIT
    } kind_t;

    // one queued word; for an emit, addr carries the video address
    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic [COL_W-1:0]    col;
        logic [LINE_W-1:0]   line;
        logic                line_end;
        logic                frame_end;
    } q_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/tmcd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tmcd_front
    import tmcd_pkg::*;
#(
    parameter int COLUMNS   = 64,
    parameter int CHAR_ROWS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic [1:0]         op,
    input  wire logic [ADDR_W-1:0]  addr,
    input  wire logic [DATA_W-1:0]  data,
    input  wire logic               q_full,
    input  wire logic               clearing,
    output logic                    push,
    output q_entry_t                push_entry
);

    localparam int LAST_LINE = CHAR_ROWS * CELL_LINES - 1;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic               accept;
    logic               line_end;
    logic               frame_end;
    logic [VADDR_W-1:0] vaddr;

    assign cmd_ready = !q_full && !clearing;
    assign accept    = cmd_valid && cmd_ready;
    assign line_end  = (col_reg == COL_W'(COLUMNS - 1));
    assign frame_end = line_end && (line_reg == LINE_W'(LAST_LINE));
    // char row times columns plus column, at most 1023
    assign vaddr = VADDR_W'({6'd0, line_reg[7:4]} * VADDR_W'(COLUMNS))
                 + {4'd0, col_reg};

    always_comb
    begin
        push       = 1'b0;
        col_next   = col_reg;
        line_next  = line_reg;
        push_entry = '{kind: KIND_EMIT, addr: addr, data: data, col: col_reg,
                       line: line_reg, line_end: line_end, frame_end: frame_end};
        unique case (op)
            OP_VIDEO_WR:
            begin
                push_entry.kind = KIND_VIDEO_WR;
                push = accept;
            end
            OP_GLYPH_WR:
            begin
                push_entry.kind = KIND_GLYPH_WR;
                push = accept;
            end
            OP_EMIT:
            begin
                push_entry.addr = {1'b0, vaddr};
                push = accept;
                if (accept)
                begin
                    if (line_end)
                    begin
                        col_next  = '0;
                        line_next = frame_end ? '0 : line_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                // unused code: taken and dropped
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tmcd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tmcd_queue
    import tmcd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  q_entry_t      push_entry,
    input  wire logic     pop,
    output logic          q_full,
    output logic          q_valid,
    output q_entry_t      head
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tmcd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tmcd_back
    import tmcd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  q_entry_t                head,
    output logic                    pop,
    output logic                    clearing,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [DATA_W-1:0]       pixels,
    output logic [COL_W-1:0]        column,
    output logic [LINE_W-1:0]       scan_line,
    output logic                    line_end,
    output logic                    frame_end
);

    logic [DATA_W-1:0]  video_mem [VIDEO_DEPTH];
    logic [DATA_W-1:0]  glyph_mem [GLYPH_DEPTH];

    logic [VADDR_W:0]   clr_cnt_reg, clr_cnt_next;
    logic               adv;
    logic               vid_we;
    logic [VADDR_W-1:0] vid_wa;
    logic [DATA_W-1:0]  vid_wd;
    logic               gly_we;
    logic [ADDR_W-1:0]  gaddr;

    // stage one: video byte read
    logic               s1_valid_reg, s1_valid_next;
    logic [DATA_W-1:0]  vdat_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [LINE_W-1:0]  s1_line_reg;
    logic               s1_line_end_reg;
    logic               s1_frame_end_reg;

    // stage two: glyph byte read, doubles as the output register
    logic               out_valid_reg;
    logic [DATA_W-1:0]  gdat_reg;
    logic               inv_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [LINE_W-1:0]  out_line_reg;
    logic               out_line_end_reg;
    logic               out_frame_end_reg;

    assign clearing     = !clr_cnt_reg[VADDR_W];
    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign adv          = !out_valid_reg || res_ready;
    assign pop          = adv && q_valid && !clearing;

    assign vid_we = clearing || (pop && head.kind == KIND_VIDEO_WR);
    assign vid_wa = clearing ? clr_cnt_reg[VADDR_W-1:0] : head.addr[VADDR_W-1:0];
    assign vid_wd = clearing ? '0 : head.data;
    assign gly_we = pop && head.kind == KIND_GLYPH_WR;
    assign s1_valid_next = pop && head.kind == KIND_EMIT;

    // lines 8 to 15 of a cell read the upper half of the glyph store
    assign gaddr = {s1_line_reg[3], vdat_reg[6:0], s1_line_reg[2:0]};

    always_ff @(posedge clk)
    begin
        if (vid_we)
        begin
            video_mem[vid_wa] <= vid_wd;
        end
        if (adv)
        begin
            vdat_reg <= video_mem[head.addr[VADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gly_we)
        begin
            glyph_mem[head.addr] <= head.data;
        end
        if (adv && s1_valid_reg)
        begin
            gdat_reg <= glyph_mem[gaddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg        <= head.col;
            s1_line_reg       <= head.line;
            s1_line_end_reg   <= head.line_end;
            s1_frame_end_reg  <= head.frame_end;
            inv_reg           <= vdat_reg[7];
            out_col_reg       <= s1_col_reg;
            out_line_reg      <= s1_line_reg;
            out_line_end_reg  <= s1_line_end_reg;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (adv)
            begin
                s1_valid_reg  <= s1_valid_next;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign pixels    = gdat_reg ^ {DATA_W{inv_reg}};
    assign column    = out_col_reg;
    assign scan_line = out_line_reg;
    assign line_end  = out_line_end_reg;
    assign frame_end = out_frame_end_reg;

endmodule

`default_nettype wire

FILE: rtl/core/text_mode_character_display.sv
// Text display slice generator, COLUMNS x CHAR_ROWS cells of 8 x 16 pixels.
// Command channel (cmd_valid/cmd_ready, op/addr/data) takes one word per
// cycle while cmd_ready is high: op 0 writes the video store, op 1 the
// glyph store, op 2 asks for the next 8-pixel slice in raster order, op 3
// is taken and ignored. Result channel (res_valid/res_ready) gives one word
// per emit: pixels, column, scan_line, line_end and frame_end.
// Throughput is one command per cycle sustained while res_ready stays high;
// an emit's result passes the queue, the registered video read and then the
// registered glyph read.
// A two-word queue parts the command decode and raster counters from the
// store pipeline, so up to two more commands are taken while a result waits.
// After reset the video store is cleared, one entry a cycle, through all 1024
// entries; cmd_ready stays low until it ends. The raster starts top left.
// The glyph store is unknown until written and must be loaded first.
// When res_ready is low while a result waits, the store pipeline holds,
// the queue fills and cmd_ready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_character_display
    import tmcd_pkg::*;
#(
    parameter int COLUMNS   = 64,
    parameter int CHAR_ROWS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic [1:0]         op,
    input  wire logic [ADDR_W-1:0]  addr,
    input  wire logic [DATA_W-1:0]  data,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [DATA_W-1:0]       pixels,
    output logic [COL_W-1:0]        column,
    output logic [LINE_W-1:0]       scan_line,
    output logic                    line_end,
    output logic                    frame_end
);

    logic     q_full;
    logic     q_valid;
    logic     clearing;
    logic     push;
    logic     pop;
    q_entry_t push_entry;
    q_entry_t head;

    tmcd_front #(
        .COLUMNS   (COLUMNS),
        .CHAR_ROWS (CHAR_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .op         (op),
        .addr       (addr),
        .data       (data),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_entry (push_entry)
    );

    tmcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .head       (head)
    );

    tmcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pixels    (pixels),
        .column    (column),
        .scan_line (scan_line),
        .line_end  (line_end),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tmcd_pkg::*;

    localparam int COLUMNS      = 64;
    localparam int CHAR_ROWS    = 16;
    localparam int FRAME_SLICES = COLUMNS * CHAR_ROWS * CELL_LINES;
    localparam int RANDOM_WORDS = 1150;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_CAP   = 200;

    localparam logic [1:0]        OP_UNUSED   = 2'd3;
    localparam logic [ADDR_W-1:0] GLYPH_UPPER = 11'h400;

    typedef struct packed {
        logic [DATA_W-1:0] pixels;
        logic [COL_W-1:0]  column;
        logic [LINE_W-1:0] scan_line;
        logic              line_end;
        logic              frame_end;
    } slice_t;

    class slice_scoreboard;
        logic [DATA_W-1:0] video_mem [VIDEO_DEPTH];
        logic [DATA_W-1:0] glyph_mem [GLYPH_DEPTH];
        bit                glyph_loaded [GLYPH_DEPTH];
        int unsigned       raster_pos;
        int unsigned       errors;
        slice_t            expected_slices [$];

        function new();
            foreach (video_mem[i])
            begin
                video_mem[i] = '0;
            end
            foreach (glyph_mem[i])
            begin
                glyph_mem[i]    = '0;
                glyph_loaded[i] = 1'b0;
            end
            raster_pos  = 0;
            errors      = 0;
        endfunction

        function logic [VADDR_W-1:0] video_addr_at(int unsigned pos);
            int unsigned char_row;
            char_row = (pos / COLUMNS) / CELL_LINES;
            return VADDR_W'(char_row * COLUMNS + pos % COLUMNS);
        endfunction

        // glyph byte that the slice at this raster position reads
        function logic [ADDR_W-1:0] glyph_addr_at(int unsigned pos);
            logic [DATA_W-1:0] vbyte;
            logic [3:0]        cell_line;
            logic [ADDR_W-1:0] gaddr;
            vbyte     = video_mem[video_addr_at(pos)];
            cell_line = 4'((pos / COLUMNS) % CELL_LINES);
            gaddr     = {1'b0, vbyte[6:0], cell_line[2:0]};
            if (cell_line[3])
                gaddr = gaddr | GLYPH_UPPER;
            return gaddr;
        endfunction

        function int unsigned pending();
            return expected_slices.size();
        endfunction

        function void note_word(logic [1:0] code, logic [ADDR_W-1:0] a,
                                logic [DATA_W-1:0] d);
            slice_t            s;
            logic [DATA_W-1:0] vbyte;
            int unsigned       col;
            int unsigned       line;
            case (code)
                OP_VIDEO_WR:
                begin
                    video_mem[a[VADDR_W-1:0]] = d;
                end
                OP_GLYPH_WR:
                begin
                    glyph_mem[a]    = d;
                    glyph_loaded[a] = 1'b1;
                end
                OP_EMIT:
                begin
                    col         = raster_pos % COLUMNS;
                    line        = raster_pos / COLUMNS;
                    vbyte       = video_mem[video_addr_at(raster_pos)];
                    s.pixels    = glyph_mem[glyph_addr_at(raster_pos)] ^ {DATA_W{vbyte[7]}};
                    s.column    = COL_W'(col);
                    s.scan_line = LINE_W'(line);
                    s.line_end  = (col == COLUMNS - 1);
                    s.frame_end = (raster_pos == FRAME_SLICES - 1);
                    expected_slices.push_back(s);
                    raster_pos++;
                    if (raster_pos >= FRAME_SLICES)
                    begin
                        raster_pos = 0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_slice(slice_t got);
            slice_t want;
            if (expected_slices.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected word, expected none got %h", $time, got);
                return;
            end
            want = expected_slices.pop_front();
            if (want === got)
                return;
            errors++;
            // keep the log bounded when the block is badly broken
            if (errors > REPORT_CAP)
                return;
            if (want.pixels !== got.pixels)
                $display("%0t: pixels expected %h got %h", $time, want.pixels, got.pixels);
            if (want.column !== got.column)
                $display("%0t: column expected %0d got %0d", $time, want.column, got.column);
            if (want.scan_line !== got.scan_line)
                $display("%0t: scan_line expected %0d got %0d", $time,
                         want.scan_line, got.scan_line);
            if (want.line_end !== got.line_end)
                $display("%0t: line_end expected %b got %b", $time,
                         want.line_end, got.line_end);
            if (want.frame_end !== got.frame_end)
                $display("%0t: frame_end expected %b got %b", $time,
                         want.frame_end, got.frame_end);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              res_valid;
    logic              res_ready;
    logic [DATA_W-1:0] pixels;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] scan_line;
    logic              line_end;
    logic              frame_end;

    bit                quiet;
    int unsigned       cycle_count = 0;
    int unsigned       words_sent = 0;
    slice_scoreboard   board;

    text_mode_character_display #(
        .COLUMNS   (COLUMNS),
        .CHAR_ROWS (CHAR_ROWS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .op        (op),
        .addr      (addr),
        .data      (data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pixels    (pixels),
        .column    (column),
        .scan_line (scan_line),
        .line_end  (line_end),
        .frame_end (frame_end)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side: check every accepted word, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                board.check_slice({pixels, column, scan_line, line_end, frame_end});
            res_ready <= quiet || ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic send_word(input logic [1:0] code, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d);
        while (!quiet && $urandom_range(0, 99) < 17)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        op        <= code;
        addr      <= a;
        data      <= d;
        do
            @(posedge clk);
        while (!cmd_ready);
        board.note_word(code, a, d);
        words_sent++;
    endtask

    // load the glyph byte the next slice needs before asking for it
    task automatic emit_slice();
        logic [ADDR_W-1:0] g;
        g = board.glyph_addr_at(board.raster_pos);
        if (!board.glyph_loaded[g])
            send_word(OP_GLYPH_WR, g, DATA_W'($urandom));
        send_word(OP_EMIT, ADDR_W'($urandom), DATA_W'($urandom));
    endtask

    initial
    begin
        int unsigned        pick;
        logic [VADDR_W-1:0] vaddr;

        board     = new();
        quiet     = 1'b0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        op        = OP_UNUSED;
        addr      = '0;
        data      = '0;
        res_ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored op, wrapped video address, store extremes
        send_word(OP_UNUSED, 11'h7ff, 8'hff);
        emit_slice();
        send_word(OP_VIDEO_WR, 11'h400, 8'h81);
        send_word(OP_VIDEO_WR, 11'h001, 8'h7f);
        send_word(OP_VIDEO_WR, 11'h002, 8'h00);
        send_word(OP_VIDEO_WR, 11'h7ff, 8'hff);
        send_word(OP_GLYPH_WR, 11'h7ff, 8'hff);
        send_word(OP_GLYPH_WR, 11'h000, 8'h00);
        send_word(OP_GLYPH_WR, 11'h009, 8'h3c);
        send_word(OP_GLYPH_WR, 11'h3f9, 8'h81);
        send_word(OP_GLYPH_WR, 11'h401, 8'ha5);
        emit_slice();
        emit_slice();
        emit_slice();
        send_word(OP_UNUSED, 11'h000, 8'h00);
        send_word(OP_VIDEO_WR, 11'h004, 8'hff);
        emit_slice();
        emit_slice();
        send_word(OP_EMIT, 11'h7ff, 8'hff);
        send_word(OP_EMIT, 11'h000, 8'h00);

        // random: mostly slices
        while (words_sent < RANDOM_WORDS)
        begin
            quiet = (words_sent >= 400 && words_sent < 700);
            pick  = $urandom_range(0, 99);
            if (pick < 65)
                emit_slice();
            else if (pick < 74)
            begin
                // a cell in the current character row, so the change shows soon
                vaddr = VADDR_W'((board.raster_pos / COLUMNS / CELL_LINES) * COLUMNS
                                 + $urandom_range(0, COLUMNS - 1));
                send_word(OP_VIDEO_WR, {1'($urandom_range(0, 1)), vaddr},
                          DATA_W'($urandom));
            end
            else if (pick < 83)
                send_word(OP_VIDEO_WR, ADDR_W'($urandom), DATA_W'($urandom));
            else if (pick < 95)
                send_word(OP_GLYPH_WR, ADDR_W'($urandom), DATA_W'($urandom));
            else
                send_word(OP_UNUSED, ADDR_W'($urandom), DATA_W'($urandom));
        end
        quiet = 1'b0;
        cmd_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
